// ===== rtl/core/lru_pkg.sv =====
// Shared types for the LRU replacement list: action and status codes
// and the control bundle broadcast from the top level to every list cell.
// No dependencies.
package lru_pkg;

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_VICTIM = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Per-transfer control broadcast to the cell chain.
  typedef struct packed {
    logic shift_all;  // every cell takes its newer neighbor's key
    logic shift_hit;  // cells at or above the matching cell shift
    logic load_en;    // one cell captures the request key
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lru_replacement_list.sv =====
// Top level of the LRU replacement list: request decode, entry count, the
// chain of lru_cell instances and the result register. Depends on lru_pkg.
//
//  Channel | Signals                                   | Direction
//  in      | in_valid_i, in_stall_o, action_i, key_i   | request into block
//  out     | out_valid_o, out_stall_i, status_o,       | result out of block
//          | victim_key_o, entries_o                   |
//
// One request per cycle: the match, shift and load across all cells settle
// in the cycle of the transfer, and the result is registered for the next.
// The match search ripples through the DEPTH cells of the chain.
// A new request is taken whenever the result register is empty or its
// result leaves in the same cycle; a stalled result stalls the input.
// Reset empties the list; key storage itself is not cleared.
module lru_replacement_list #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [KEY_BITS-1:0]         key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [KEY_BITS-1:0]         victim_key_o,
  output logic [$clog2(DEPTH+1)-1:0]  entries_o
);
  import lru_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic                 accept;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [KEY_BITS-1:0]  victim_q, victim_d;
  logic [CW-1:0]        entries_q;
  cell_ctrl_t           ctrl;
  logic [IW-1:0]        load_idx;
  logic                 hit_any;
  action_e              action;

  logic [DEPTH:0]                   found;
  logic [DEPTH-1:0][KEY_BITS-1:0]   cell_key;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign action     = action_e'(action_i);

  // Cell chain; the newest end shifts in zero.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_key[i+1];
    end
    lru_cell #(
      .IDX      (i),
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .load_idx_i (load_idx),
      .key_i      (key_i),
      .next_key_i (nxt),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .key_o      (cell_key[i])
    );
  end
  assign hit_any = found[DEPTH];

  // Request decode: chain control, next count and result fields.
  always_comb begin
    ctrl     = '0;
    load_idx = '0;
    count_d  = count_q;
    status_d = ST_DONE;
    victim_d = '0;
    unique case (action)
      ACT_INSERT: begin
        if (hit_any) begin
          ctrl.shift_hit = 1'b1;
          ctrl.load_en   = 1'b1;
          load_idx       = IW'(count_q - CW'(1));
        end else if (count_q == CW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.load_en = 1'b1;
          load_idx     = IW'(count_q);
          count_d      = count_q + CW'(1);
        end
      end
      ACT_VICTIM: begin
        if (count_q == '0) begin
          status_d = ST_NONE;
        end else begin
          ctrl.shift_all = 1'b1;
          victim_d       = cell_key[0];
          count_d        = count_q - CW'(1);
        end
      end
      ACT_ERASE: begin
        if (hit_any) begin
          ctrl.shift_hit = 1'b1;
          count_d        = count_q - CW'(1);
        end else begin
          status_d = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = accept || in_stall_o;

  // Control state: entry count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      victim_q  <= victim_d;
      entries_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign victim_key_o = victim_q;
  assign entries_o    = entries_q;

endmodule

// ===== rtl/core/lru_cell.sv =====
// One position of the LRU list: holds a key, compares it with the request
// key and shifts or loads on a transfer. Depends on lru_pkg.
module lru_cell #(
  parameter int IDX      = 0,
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  lru_pkg::cell_ctrl_t              ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]       count_i,
  input  logic [$clog2(DEPTH)-1:0]         load_idx_i,
  input  logic [KEY_BITS-1:0]              key_i,
  input  logic [KEY_BITS-1:0]              next_key_i,
  input  logic                             found_i,
  output logic                             found_o,
  output logic [KEY_BITS-1:0]              key_o
);
  import lru_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                in_list;
  logic                hit;
  logic                load_here;

  // Match only within the occupied part of the list.
  assign in_list = CW'(IDX) < count_i;
  assign hit     = in_list && (key_q == key_i);
  assign found_o = found_i | hit;

  assign load_here = ctrl_i.load_en && (load_idx_i == IW'(IDX));

  // Load has priority over shifting in from the newer neighbor.
  always_comb begin
    key_d = key_q;
    if (load_here) begin
      key_d = key_i;
    end else if (ctrl_i.shift_all || (ctrl_i.shift_hit && found_o)) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== rtl/core/lru_checker.sv =====
// Port-level checks for lru_replacement_list, attached by the bind below.
// Depends on lru_pkg.
module lru_checker #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [KEY_BITS-1:0]         victim_key_o,
  input logic [$clog2(DEPTH+1)-1:0]  entries_o
);
  import lru_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // The count never exceeds the list capacity.
  a_entries_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_o <= CW'(DEPTH))
    else $error("entries above capacity");

  // A refused insert only happens on a full list.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> entries_o == CW'(DEPTH))
    else $error("full status with room left");

  // A returned victim key comes only with a successful result.
  a_victim_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && victim_key_o != '0) |-> status_o == ST_DONE)
    else $error("victim key on a failed result");

  // The input stalls only while a result is held.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A stalled result holds until its transfer.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(victim_key_o) && $stable(entries_o)))
    else $error("stalled result changed");

endmodule

bind lru_replacement_list lru_checker #(
  .DEPTH    (DEPTH),
  .KEY_BITS (KEY_BITS)
) u_lru_checker (.*);

// ===== tb/lru_list_checker.sv =====
// Checker for the LRU replacement list: watches both channels, keeps its own
// ordered key list and compares every result transfer against it.
// Depends on lru_pkg.
`timescale 1ns / 100ps

module lru_list_checker #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  action_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  status_i,
  input  logic [KEY_BITS-1:0]         victim_key_i,
  input  logic [$clog2(DEPTH+1)-1:0]  entries_i,
  output int                          mismatch_count_o,
  output int                          results_pending_o
);
  import lru_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef struct {
    logic [1:0]                 status;
    logic [KEY_BITS-1:0]        victim_key;
    logic [$clog2(DEPTH+1)-1:0] entries;
  } lru_result_t;

  // Keys held by the list, oldest at index zero.
  logic [KEY_BITS-1:0] held_keys[$];
  // Results predicted for accepted requests, oldest first.
  lru_result_t         awaited_results[$];
  int                  mismatches = 0;

  assign mismatch_count_o  = mismatches;
  assign results_pending_o = awaited_results.size();

  // Applies one request to the key list and returns the result it produces.
  function automatic lru_result_t apply_request(logic [1:0] act, logic [KEY_BITS-1:0] k);
    lru_result_t r;
    int          hit_pos;
    r.status     = ST_DONE;
    r.victim_key = '0;
    hit_pos      = -1;
    foreach (held_keys[i]) begin
      if (hit_pos < 0 && held_keys[i] == k) hit_pos = i;
    end
    case (act)
      ACT_INSERT: begin
        // A present key moves to the newest end even when the list is full.
        if (hit_pos >= 0) begin
          held_keys.delete(hit_pos);
          held_keys.insert(held_keys.size(), k);
        end else if (held_keys.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_keys.insert(held_keys.size(), k);
        end
      end
      ACT_VICTIM: begin
        if (held_keys.size() == 0) begin
          r.status = ST_NONE;
        end else begin
          r.victim_key = held_keys[0];
          held_keys.delete(0);
        end
      end
      ACT_ERASE: begin
        if (hit_pos >= 0) held_keys.delete(hit_pos);
        else r.status = ST_NONE;
      end
      default: begin
        // The unused code leaves the list untouched.
      end
    endcase
    r.entries = CW'(held_keys.size());
    return r;
  endfunction

  // Compare result transfers first, then predict for the request transfer
  // of the same edge; a result always belongs to an earlier request.
  always @(posedge clk_i) begin
    lru_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches++;
          end
          if (victim_key_i !== want.victim_key) begin
            $error("victim_key: expected %0h, got %0h", want.victim_key, victim_key_i);
            mismatches++;
          end
          if (entries_i !== want.entries) begin
            $error("entries: expected %0d, got %0d", want.entries, entries_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_request(action_i, key_i);
        awaited_results.insert(awaited_results.size(), want);
      end
    end
  end

endmodule

// ===== tb/lru_replacement_list_tb.sv =====
// Top of the LRU replacement list testbench: clock, reset, request stimulus
// and random result stalls. Depends on lru_pkg, lru_replacement_list and
// lru_list_checker.
`timescale 1ns / 100ps

module lru_replacement_list_tb;
  import lru_pkg::*;

  localparam int DEPTH       = 16;
  localparam int KEY_BITS    = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 22;
  localparam int SEG_ITEMS   = 50;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  action_i;
  logic [KEY_BITS-1:0]         key_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [1:0]                  status_o;
  logic [KEY_BITS-1:0]         victim_key_o;
  logic [$clog2(DEPTH+1)-1:0]  entries_o;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  bit quiet       = 1'b0;  // no idling on either side
  bit calm        = 1'b0;  // no idling in the current segment

  lru_replacement_list #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .victim_key_o (victim_key_o),
    .entries_o    (entries_o)
  );

  lru_list_checker #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .action_i          (action_i),
    .key_i             (key_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .victim_key_i      (victim_key_o),
    .entries_i         (entries_o),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side stalls in random bursts.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && !calm && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Presents one request and holds it until the transfer happens.
  task automatic send_request(action_e act, logic [KEY_BITS-1:0] k);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Leaves the request side idle for a number of cycles.
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Idles the request side until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  // Reset, directed requests, random segments and the verdict.
  initial begin
    int                  span;
    int                  insert_pct;
    int                  roll;
    logic [KEY_BITS-1:0] base_key;
    logic [KEY_BITS-1:0] k;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ACT_NOP;
    key_i      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: victim and erase both miss; the unused code does nothing.
    send_request(ACT_VICTIM, 8'h5A);
    send_request(ACT_ERASE, 8'hFF);
    send_request(ACT_NOP, 8'hAA);
    // Extreme keys, a touch that reorders, and a victim of the oldest.
    send_request(ACT_INSERT, 8'h00);
    send_request(ACT_INSERT, 8'hFF);
    send_request(ACT_INSERT, 8'h00);
    send_request(ACT_VICTIM, 8'h00);
    // Fill the list, then a refused insert, a touch while full, and erases that hit and miss.
    for (int i = 1; i < DEPTH; i++) send_request(ACT_INSERT, KEY_BITS'(i));
    send_request(ACT_INSERT, 8'h80);
    send_request(ACT_INSERT, 8'h00);
    send_request(ACT_ERASE, 8'h07);
    send_request(ACT_ERASE, 8'h77);
    drain_results();

    // Random segments: each draws keys from a window so that hits, fills
    // and drains all happen; the last segments run without any idling.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      quiet    = (seg >= SEGMENTS - 3);
      calm     = ($urandom_range(0, 3) == 0);
      base_key = KEY_BITS'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
        0: span = 4;
        1: span = 12;
        2: span = 18;
        3: span = 24;
        default: span = 256;
      endcase
      case ($urandom_range(0, 2))
        0: insert_pct = 70;
        1: insert_pct = 45;
        default: insert_pct = 25;
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        k    = KEY_BITS'(base_key + $urandom_range(0, span - 1));
        if (roll < insert_pct) send_request(ACT_INSERT, k);
        else if (roll >= 97) send_request(ACT_NOP, k);
        else if ($urandom_range(0, 1) == 0) send_request(ACT_VICTIM, k);
        else send_request(ACT_ERASE, k);
        if (!quiet && !calm && $urandom_range(0, 4) == 0)
          pause_sender($urandom_range(1, 6));
      end
      // Now and then hold off until the block has caught up completely.
      if (seg % 7 == 3) drain_results();
    end

    drain_results();
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
